### rtl/assert_macros.svh
// Assertion macros used by sorted_priority_list.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SPL_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define SPL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/spl_pkg.sv
`default_nettype none
package spl_pkg;

  localparam int CAPACITY     = 64;
  localparam int NODE_BITS    = 16;
  localparam int COST_BITS    = 32;
  localparam int PAYLOAD_BITS = 16;
  localparam int COUNT_BITS   = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_FIND   = 2'd2,
    FUNC_PEEK   = 2'd3
  } func_t;

  typedef struct packed {
    logic [NODE_BITS-1:0]    node;
    logic [COST_BITS-1:0]    cost;
    logic [PAYLOAD_BITS-1:0] payload;
  } rec_t;

  localparam int REC_BITS = $bits(rec_t);

  typedef struct packed {
    logic load_new;
    logic take_left;
    logic take_right;
  } cell_ctl_t;

endpackage
`default_nettype wire

### rtl/spl_cell.sv
`default_nettype none
module spl_cell (
  input  wire logic                          clk,
  input  wire logic                          eval,
  input  wire logic                          valid,
  input  wire logic [spl_pkg::NODE_BITS-1:0] key_node,
  input  wire logic [spl_pkg::COST_BITS-1:0] key_cost,
  input  wire spl_pkg::rec_t                 new_rec,
  input  wire spl_pkg::rec_t                 left_rec,
  input  wire spl_pkg::rec_t                 right_rec,
  input  wire spl_pkg::cell_ctl_t            ctl,
  output spl_pkg::rec_t                      rec,
  output logic                               match,
  output logic                               le
);

  always_ff @(posedge clk) begin
    if (eval) begin
      match <= valid && (rec.node == key_node);
      le    <= valid && (key_cost <= rec.cost);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_new) begin
      rec <= new_rec;
    end else if (ctl.take_left) begin
      rec <= left_rec;
    end else if (ctl.take_right) begin
      rec <= right_rec;
    end
  end

endmodule
`default_nettype wire

### rtl/sorted_priority_list.sv
// Each operation passes through the EVAL state, in which every cell compares its record
// with the command, then the COMMIT state, in which the cells shift or load.
// done is high for one cycle, registered from the COMMIT state.
// A new transfer can be accepted in the COMMIT state; the receiver cannot stall.
// Reset clears the entry count and the control state; record storage is not cleared.
`default_nettype none
`include "assert_macros.svh"
module sorted_priority_list (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [1:0]                       func,
  input  wire logic [spl_pkg::NODE_BITS-1:0]    node_id,
  input  wire logic [spl_pkg::COST_BITS-1:0]    cost,
  input  wire logic [spl_pkg::PAYLOAD_BITS-1:0] payload,
  output logic                                  done,
  output logic                                  found,
  output logic [spl_pkg::NODE_BITS-1:0]         out_node,
  output logic [spl_pkg::COST_BITS-1:0]         out_cost,
  output logic [spl_pkg::PAYLOAD_BITS-1:0]      out_payload,
  output logic                                  overflow,
  output logic [spl_pkg::COUNT_BITS-1:0]        entry_count
);

  localparam int N = spl_pkg::CAPACITY;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_EVAL   = 3'b010,
    ST_COMMIT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  spl_pkg::func_t                     cmd_func;
  spl_pkg::rec_t                      cmd_rec;
  logic [spl_pkg::COUNT_BITS-1:0]     count;
  logic [spl_pkg::COUNT_BITS-1:0]     count_next;

  spl_pkg::rec_t     recs [N];
  spl_pkg::cell_ctl_t ctls [N];
  logic [N-1:0]      valid;
  logic [N-1:0]      match_vec;
  logic [N-1:0]      le_vec;
  logic [N-1:0]      ge_ins;
  logic [N-1:0]      ge_prev;
  logic [N-1:0]      match_dec;
  logic [N-1:0]      below;
  logic [N-1:0]      first;
  logic [N-1:0]      sel;
  logic [spl_pkg::REC_BITS-1:0] sel_bits;

  logic accept;
  logic full;
  logic any_match;
  logic ins_ok;
  logic rm_hit;
  logic commit;
  logic res_found;

  assign accept = start && !busy;
  assign busy   = (state == ST_EVAL);
  assign commit = (state == ST_COMMIT);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_EVAL;
      ST_EVAL:   state_next = ST_COMMIT;
      ST_COMMIT: state_next = accept ? ST_EVAL : ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (commit) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_func        <= spl_pkg::func_t'(func);
      cmd_rec.node    <= node_id;
      cmd_rec.cost    <= cost;
      cmd_rec.payload <= payload;
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      valid[i] = (spl_pkg::COUNT_BITS'(i) < count);
    end
  end

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      localparam int L = (g == 0) ? 0 : g - 1;
      localparam int R = (g == N - 1) ? g : g + 1;
      spl_cell u_cell (
        .clk       (clk),
        .eval      (busy),
        .valid     (valid[g]),
        .key_node  (cmd_rec.node),
        .key_cost  (cmd_rec.cost),
        .new_rec   (cmd_rec),
        .left_rec  (recs[L]),
        .right_rec (recs[R]),
        .ctl       (ctls[g]),
        .rec       (recs[g]),
        .match     (match_vec[g]),
        .le        (le_vec[g])
      );
    end
  endgenerate

  assign full      = (count == spl_pkg::COUNT_BITS'(N));
  assign any_match = |match_vec;
  assign ins_ok    = commit && (cmd_func == spl_pkg::FUNC_INSERT) && !full;
  assign rm_hit    = commit && (cmd_func == spl_pkg::FUNC_REMOVE) && any_match;

  // The stored costs are ascending, so the insert boundary is a single step in ge_ins.
  assign ge_ins    = ~valid | le_vec;
  assign ge_prev   = {ge_ins[N-2:0], 1'b0};
  assign match_dec = match_vec - N'(1);
  assign below     = match_dec & ~match_vec;
  assign first     = match_vec & ~match_dec;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      ctls[i].load_new   = ins_ok && ge_ins[i] && !ge_prev[i];
      ctls[i].take_left  = ins_ok && ge_ins[i] && ge_prev[i];
      ctls[i].take_right = rm_hit && !below[i];
    end
  end

  always_comb begin
    sel       = '0;
    res_found = 1'b0;
    unique case (cmd_func) inside
      spl_pkg::FUNC_REMOVE, spl_pkg::FUNC_FIND: begin
        sel       = first;
        res_found = any_match;
      end
      spl_pkg::FUNC_PEEK: begin
        sel[0]    = (count != '0);
        res_found = (count != '0);
      end
      default: begin
        sel       = '0;
        res_found = 1'b0;
      end
    endcase
  end

  always_comb begin
    sel_bits = '0;
    for (int i = 0; i < N; i++) begin
      sel_bits = sel_bits | (recs[i] & {spl_pkg::REC_BITS{sel[i]}});
    end
  end

  always_comb begin
    if (ins_ok) begin
      count_next = count + spl_pkg::COUNT_BITS'(1);
    end else if (rm_hit) begin
      count_next = count - spl_pkg::COUNT_BITS'(1);
    end else begin
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= commit;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      found       <= res_found;
      {out_node, out_cost, out_payload} <= sel_bits;
      overflow    <= (cmd_func == spl_pkg::FUNC_INSERT) && full;
      entry_count <= count_next;
    end
  end

  `SPL_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= spl_pkg::COUNT_BITS'(N))
  `SPL_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy)
  `SPL_ASSERT_NEXT(a_busy_done, clk, rst, busy, commit)
  `SPL_ASSERT_NOW(a_sel_onehot, clk, rst, commit, $onehot0(sel))
  `SPL_ASSERT_NOW(a_ovf_excl, clk, rst, done, !(overflow && found))

endmodule
`default_nettype wire

### test/testbench.sv
`timescale 1ns / 100ps
module testbench;

  typedef logic [spl_pkg::NODE_BITS-1:0]    node_t;
  typedef logic [spl_pkg::COST_BITS-1:0]    cost_t;
  typedef logic [spl_pkg::PAYLOAD_BITS-1:0] payload_t;
  typedef logic [spl_pkg::COUNT_BITS-1:0]   count_t;

  typedef struct {
    logic     found;
    node_t    node;
    cost_t    cost;
    payload_t payload;
    logic     overflow;
    count_t   count;
  } list_result_t;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic [1:0]              func;
  node_t                   node_id;
  cost_t                   cost;
  payload_t                payload;
  logic                    done;
  logic                    found;
  node_t                   out_node;
  cost_t                   out_cost;
  payload_t                out_payload;
  logic                    overflow;
  count_t                  entry_count;

  spl_pkg::rec_t open_list [spl_pkg::CAPACITY];
  int            open_count;
  list_result_t  pending_results[$];
  int            fail_count;
  bit            steady_flow;

  sorted_priority_list u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .node_id     (node_id),
    .cost        (cost),
    .payload     (payload),
    .done        (done),
    .found       (found),
    .out_node    (out_node),
    .out_cost    (out_cost),
    .out_payload (out_payload),
    .overflow    (overflow),
    .entry_count (entry_count)
  );

  always #2 clk = ~clk;

  // Applies one operation to the open list copy and returns the result it should produce.
  function automatic list_result_t apply_list_op(spl_pkg::func_t op, node_t nd,
                                                 cost_t cs, payload_t pl);
    list_result_t r;
    int           pos;
    r = '{default: '0};
    pos = -1;
    if (op == spl_pkg::FUNC_INSERT) begin
      if (open_count >= spl_pkg::CAPACITY) begin
        r.overflow = 1'b1;
      end else begin
        pos = 0;
        while (pos < open_count && cs > open_list[pos].cost) pos++;
        for (int i = open_count; i > pos; i--) open_list[i] = open_list[i-1];
        open_list[pos] = '{node: nd, cost: cs, payload: pl};
        open_count++;
      end
    end else begin
      if (op == spl_pkg::FUNC_PEEK) begin
        if (open_count > 0) pos = 0;
      end else begin
        for (int i = 0; i < open_count; i++) begin
          if (pos < 0 && open_list[i].node == nd) pos = i;
        end
      end
      if (pos >= 0) begin
        r.found   = 1'b1;
        r.node    = open_list[pos].node;
        r.cost    = open_list[pos].cost;
        r.payload = open_list[pos].payload;
        if (op == spl_pkg::FUNC_REMOVE) begin
          for (int i = pos; i < open_count - 1; i++) open_list[i] = open_list[i+1];
          open_count--;
        end
      end
    end
    r.count = open_count[spl_pkg::COUNT_BITS-1:0];
    return r;
  endfunction

  task automatic issue_op(input spl_pkg::func_t op, input node_t nd,
                          input cost_t cs, input payload_t pl);
    start   <= 1'b1;
    func    <= op;
    node_id <= nd;
    cost    <= cs;
    payload <= pl;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.insert(pending_results.size(), apply_list_op(op, nd, cs, pl));
    if (!steady_flow && $urandom_range(99) < 38) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic node_t pick_node();
    int r;
    r = $urandom_range(99);
    if (open_count > 0 && r < 50) return open_list[$urandom_range(open_count - 1)].node;
    if (r < 80) return node_t'($urandom_range(15));
    return node_t'($urandom);
  endfunction

  function automatic cost_t pick_cost();
    int r;
    r = $urandom_range(99);
    if (r < 40) return cost_t'($urandom_range(20));
    if (r < 45) return '0;
    if (r < 50) return '1;
    return cost_t'($urandom);
  endfunction

  function automatic spl_pkg::func_t pick_op(int insert_weight);
    int r;
    r = $urandom_range(insert_weight + 59);
    if (r < insert_weight) return spl_pkg::FUNC_INSERT;
    if (r < insert_weight + 25) return spl_pkg::FUNC_REMOVE;
    if (r < insert_weight + 45) return spl_pkg::FUNC_FIND;
    return spl_pkg::FUNC_PEEK;
  endfunction

  task automatic issue_random(input int insert_weight);
    issue_op(pick_op(insert_weight), pick_node(), pick_cost(), payload_t'($urandom));
  endtask

  task automatic test_empty_store();
    issue_op(spl_pkg::FUNC_PEEK, 16'h0000, 32'h0, 16'h0000);
    issue_op(spl_pkg::FUNC_FIND, 16'h0000, 32'hFFFF_FFFF, 16'hFFFF);
    issue_op(spl_pkg::FUNC_REMOVE, 16'hFFFF, 32'h0, 16'h0000);
    wait_drained();
  endtask

  task automatic test_directed_ops();
    issue_op(spl_pkg::FUNC_INSERT, 16'h0001, 32'd100, 16'hAAAA);
    issue_op(spl_pkg::FUNC_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    issue_op(spl_pkg::FUNC_INSERT, 16'h0000, 32'h0, 16'h0000);
    // Equal cost goes ahead of the older entry.
    issue_op(spl_pkg::FUNC_INSERT, 16'h0002, 32'd100, 16'h5555);
    issue_op(spl_pkg::FUNC_PEEK, 16'h1234, 32'h0, 16'h0000);
    issue_op(spl_pkg::FUNC_FIND, 16'h0002, 32'h0, 16'h0000);
    issue_op(spl_pkg::FUNC_FIND, 16'hFFFF, 32'h0, 16'h0000);
    issue_op(spl_pkg::FUNC_FIND, 16'h1234, 32'h0, 16'h0000);
    // A duplicate node id ahead of the first one; remove takes the lower position.
    issue_op(spl_pkg::FUNC_INSERT, 16'h0001, 32'd50, 16'h1111);
    issue_op(spl_pkg::FUNC_REMOVE, 16'h0001, 32'h0, 16'h0000);
    issue_op(spl_pkg::FUNC_FIND, 16'h0001, 32'h0, 16'h0000);
    issue_op(spl_pkg::FUNC_REMOVE, 16'h0000, 32'h0, 16'h0000);
    issue_op(spl_pkg::FUNC_PEEK, 16'h0000, 32'h0, 16'h0000);
    issue_op(spl_pkg::FUNC_REMOVE, 16'h9999, 32'h0, 16'h0000);
    issue_op(spl_pkg::FUNC_REMOVE, 16'hFFFF, 32'h0, 16'h0000);
    issue_op(spl_pkg::FUNC_REMOVE, 16'h0002, 32'h0, 16'h0000);
    issue_op(spl_pkg::FUNC_REMOVE, 16'h0001, 32'h0, 16'h0000);
    issue_op(spl_pkg::FUNC_PEEK, 16'hFFFF, 32'h0, 16'h0000);
    wait_drained();
  endtask

  task automatic test_random_mixed();
    for (int n = 0; n < 150; n++) issue_random(40);
    wait_drained();
  endtask

  task automatic test_fill_and_drain();
    while (open_count < spl_pkg::CAPACITY) begin
      if ($urandom_range(9) == 0) begin
        issue_op(spl_pkg::FUNC_FIND, pick_node(), pick_cost(), 16'h0);
      end else begin
        issue_op(spl_pkg::FUNC_INSERT, pick_node(), pick_cost(), payload_t'($urandom));
      end
    end
    // Inserts on a full store are dropped.
    repeat (6) issue_op(spl_pkg::FUNC_INSERT, node_t'($urandom), pick_cost(),
                        payload_t'($urandom));
    issue_op(spl_pkg::FUNC_PEEK, 16'h0, 32'h0, 16'h0);
    wait_drained();
    while (open_count > 0) begin
      if ($urandom_range(7) == 0) issue_op(spl_pkg::FUNC_PEEK, pick_node(), 32'h0, 16'h0);
      else issue_op(spl_pkg::FUNC_REMOVE, open_list[$urandom_range(open_count - 1)].node,
                    cost_t'($urandom), payload_t'($urandom));
    end
    issue_op(spl_pkg::FUNC_REMOVE, pick_node(), 32'h0, 16'h0);
    wait_drained();
  endtask

  task automatic test_steady_churn();
    steady_flow = 1'b1;
    for (int n = 0; n < 120; n++) issue_random(35);
    steady_flow = 1'b0;
    for (int n = 0; n < 20; n++) issue_random(30);
    wait_drained();
  endtask

  always @(posedge clk) begin : result_check
    list_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with no transfer waiting for it");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (found !== want.found) begin
          $error("found: expected %0h, actual %0h", want.found, found);
          fail_count++;
        end
        if (out_node !== want.node) begin
          $error("out_node: expected %0h, actual %0h", want.node, out_node);
          fail_count++;
        end
        if (out_cost !== want.cost) begin
          $error("out_cost: expected %0h, actual %0h", want.cost, out_cost);
          fail_count++;
        end
        if (out_payload !== want.payload) begin
          $error("out_payload: expected %0h, actual %0h", want.payload, out_payload);
          fail_count++;
        end
        if (overflow !== want.overflow) begin
          $error("overflow: expected %0h, actual %0h", want.overflow, overflow);
          fail_count++;
        end
        if (entry_count !== want.count) begin
          $error("entry_count: expected %0d, actual %0d", want.count, entry_count);
          fail_count++;
        end
      end
    end
  end

  initial begin
    fail_count  = 0;
    open_count  = 0;
    steady_flow = 1'b0;
    rst     <= 1'b1;
    start   <= 1'b0;
    func    <= spl_pkg::FUNC_INSERT;
    node_id <= '0;
    cost    <= '0;
    payload <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_store();
    test_directed_ops();
    test_random_mixed();
    test_fill_and_drain();
    test_steady_churn();
    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### sorted_priority_list.f
+incdir+rtl
rtl/spl_pkg.sv
rtl/spl_cell.sv
rtl/sorted_priority_list.sv
test/testbench.sv
